FILE: rtl/core/tdcd_pkg.sv
// Shared types, codes, segment table and digit helpers for the two-digit counter display.
package tdcd_pkg;

   // Field widths
   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned SEG_W    = 7;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned RADIX_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 24;

   // Radix select codes (the unused code behaves as decimal)
   localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd0;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd1;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RADIX_SELECT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_DOWN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_PERIOD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_ENABLE  = 3'd4;

   // Item kinds
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Reset values of the registers
   localparam logic [RADIX_W-1:0]  RADIX_RESET  = RADIX_DEC;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

   // Segment patterns for digits 0..15, bit 0 is segment a
   localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
      7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
   };

   typedef struct packed {
      logic [DIGIT_W-1:0] high;
      logic [DIGIT_W-1:0] low;
   } digits_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic               advance;
      logic               mode;
      logic [VALUE_W-1:0] load_value;
   } item_type;

   typedef struct packed {
      logic               load_rejected;
      logic [VALUE_W-1:0] shown_value;
      logic               low_display_on;
      logic               high_display_on;
      logic [SEG_W-1:0]   segments;
   } result_type;

   // Largest value that fits two digits of the selected base
   function automatic logic [VALUE_W-1:0] radix_max(input logic [RADIX_W-1:0] sel);
      logic [VALUE_W-1:0] mx;
      if (sel == RADIX_BIN) begin
         mx = 8'd3;
      end else if (sel == RADIX_HEX) begin
         mx = 8'd255;
      end else begin
         mx = 8'd99;
      end
      return mx;
   endfunction

   // Split a value into high and low digits; divide by ten with a reciprocal
   function automatic digits_type split_digits(input logic [VALUE_W-1:0] v,
                                               input logic [RADIX_W-1:0] sel);
      digits_type         d;
      logic [15:0]        prod;
      logic [4:0]         quot;
      logic [VALUE_W-1:0] rem;
      prod = 16'(v) * 16'd205;
      quot = prod[15:11];
      rem  = v - 8'({quot, 3'b000} + {2'b00, quot, 1'b0});
      if (sel == RADIX_BIN) begin
         d.high = v[4:1];
         d.low  = {3'b000, v[0]};
      end else if (sel == RADIX_HEX) begin
         d.high = v[7:4];
         d.low  = v[3:0];
      end else begin
         d.high = quot[3:0];
         d.low  = rem[3:0];
      end
      return d;
   endfunction

endpackage

FILE: rtl/core/two_digit_radix_counter_display_top.sv
// Top level: input register, update engine and a two-deep result buffer.
// Path: an accepted beat is held in the input register, processed by the update engine, and its
// result is registered in the result register (or the skid entry) before it shows on rsp_.
// Throughput: one beat per cycle while the skid entry is free; the state update is a single pass
// between the input register and the result register. Two results can wait while rsp_tready is low.
// Reset: synchronous, active high; clears the valid flags and all engine state and loads register
// defaults (decimal, count up, period 1000, output and counting off).
module two_digit_radix_counter_display_top (
   input  logic                               clock,
   input  logic                               reset,
   // input beats
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdcd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] load_value
   input  logic [tdcd_pkg::REQ_USER_W-1:0]    req_tuser,  // [0] mode
   // result beats
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] segments, [7] high_display_on, [8] low_display_on, [16:9] shown_value,
   // [17] load_rejected, [23:18] zero
   output logic [tdcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tdcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdcd_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int unsigned RES_W = $bits(tdcd_pkg::result_type);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_mode_ff;
   logic [tdcd_pkg::VALUE_W-1:0]  in_load_ff;

   logic                          out_valid_ff, out_valid_in;
   tdcd_pkg::result_type          out_data_ff, out_data_in;
   logic                          skid_valid_ff, skid_valid_in;
   tdcd_pkg::result_type          skid_data_ff, skid_data_in;

   logic                          advance;
   logic                          pop;
   tdcd_pkg::item_type            item;
   tdcd_pkg::csr_write_type       csr;
   tdcd_pkg::result_type          result;

   // Process the held beat whenever the result buffer has room
   assign advance    = in_valid_ff && !skid_valid_ff;
   assign req_tready = !in_valid_ff || advance;
   assign pop        = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   assign item.advance    = advance;
   assign item.mode       = in_mode_ff;
   assign item.load_value = in_load_ff;
   assign csr.valid       = csr_valid;
   assign csr.index       = csr_index;
   assign csr.data        = csr_data;

   tdcd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .csr    (csr),
      .result (result)
   );

   // Hold or replace the input beat
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser[0];
         in_load_ff <= req_tdata[tdcd_pkg::VALUE_W-1:0];
      end
   end

   // Result register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = advance;
            out_data_in  = result;
         end
      end else if (advance) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(tdcd_pkg::RSP_DATA_W - RES_W){1'b0}}, out_data_ff};

endmodule

FILE: rtl/core/tdcd_engine.sv
// Counter state, configuration registers and the per-beat display and count update.
module tdcd_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  tdcd_pkg::item_type     item,
   input  tdcd_pkg::csr_write_type csr,
   output tdcd_pkg::result_type   result
);

   // Configuration registers
   logic [tdcd_pkg::RADIX_W-1:0]  radix_ff, radix_in;
   logic                          count_down_ff, count_down_in;
   logic [tdcd_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                          output_en_ff, output_en_in;
   logic                          count_en_ff, count_en_in;

   // Counter and display state
   logic [tdcd_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [tdcd_pkg::DIGIT_W-1:0]  high_digit_ff, high_digit_in;
   logic [tdcd_pkg::DIGIT_W-1:0]  low_digit_ff, low_digit_in;
   logic                          low_active_ff, low_active_in;
   logic [tdcd_pkg::PERIOD_W-1:0] period_count_ff, period_count_in;
   logic [tdcd_pkg::SEG_W-1:0]    segment_ff, segment_in;
   logic                          high_lit_ff, high_lit_in;
   logic                          low_lit_ff, low_lit_in;

   logic [tdcd_pkg::VALUE_W-1:0]  max_value;
   logic [tdcd_pkg::VALUE_W-1:0]  stepped;
   logic [tdcd_pkg::PERIOD_W-1:0] period_next;
   tdcd_pkg::digits_type          load_digits;
   tdcd_pkg::digits_type          step_digits;
   logic                          rejected;

   // Shared arithmetic for this beat
   always_comb begin
      max_value   = tdcd_pkg::radix_max(radix_ff);
      load_digits = tdcd_pkg::split_digits(item.load_value, radix_ff);
      period_next = period_count_ff + 16'd1;
      if (!count_down_ff) begin
         stepped = (value_ff >= max_value) ? '0 : value_ff + 8'd1;
      end else begin
         stepped = (value_ff == '0) ? max_value : value_ff - 8'd1;
      end
      step_digits = tdcd_pkg::split_digits(stepped, radix_ff);
   end

   // Next state: item first, then any register write
   always_comb begin
      radix_in        = radix_ff;
      count_down_in   = count_down_ff;
      period_in       = period_ff;
      output_en_in    = output_en_ff;
      count_en_in     = count_en_ff;
      value_in        = value_ff;
      high_digit_in   = high_digit_ff;
      low_digit_in    = low_digit_ff;
      low_active_in   = low_active_ff;
      period_count_in = period_count_ff;
      segment_in      = segment_ff;
      high_lit_in     = high_lit_ff;
      low_lit_in      = low_lit_ff;
      rejected        = 1'b0;

      if (item.advance) begin
         if (item.mode == tdcd_pkg::MODE_LOAD) begin
            // Take the load if it fits two digits, flag it otherwise
            if (item.load_value <= max_value) begin
               value_in      = item.load_value;
               high_digit_in = load_digits.high;
               low_digit_in  = load_digits.low;
            end else begin
               rejected = 1'b1;
            end
         end else begin
            // Flip the active display with the digits from before this tick
            if (output_en_ff) begin
               low_active_in = ~low_active_ff;
               if (!low_active_ff) begin
                  high_lit_in = 1'b0;
                  segment_in  = tdcd_pkg::SEG_TABLE[low_digit_ff];
                  low_lit_in  = 1'b1;
               end else begin
                  low_lit_in = 1'b0;
                  if (high_digit_ff == '0) begin
                     high_lit_in = 1'b0;
                  end else begin
                     segment_in  = tdcd_pkg::SEG_TABLE[high_digit_ff];
                     high_lit_in = 1'b1;
                  end
               end
            end
            // Advance the period timer and step the value when it fires
            if (count_en_ff) begin
               if (period_next >= period_ff) begin
                  period_count_in = '0;
                  value_in        = stepped;
                  if (stepped <= max_value) begin
                     high_digit_in = step_digits.high;
                     low_digit_in  = step_digits.low;
                  end
               end else begin
                  period_count_in = period_next;
               end
            end else begin
               period_count_in = '0;
            end
         end
      end

      if (csr.valid) begin
         unique case (csr.index)
            tdcd_pkg::REG_RADIX_SELECT: begin
               radix_in = csr.data[tdcd_pkg::RADIX_W-1:0];
            end
            tdcd_pkg::REG_COUNT_DOWN: begin
               count_down_in = csr.data[0];
            end
            tdcd_pkg::REG_COUNT_PERIOD: begin
               period_in = csr.data[tdcd_pkg::PERIOD_W-1:0];
            end
            tdcd_pkg::REG_OUTPUT_ENABLE: begin
               output_en_in = csr.data[0];
               if (!csr.data[0]) begin
                  high_lit_in = 1'b0;
                  low_lit_in  = 1'b0;
               end
            end
            tdcd_pkg::REG_COUNT_ENABLE: begin
               count_en_in = csr.data[0];
               if (!csr.data[0]) begin
                  period_count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result of this beat, taken from the updated state
   always_comb begin
      result.segments        = segment_in;
      result.high_display_on = high_lit_in;
      result.low_display_on  = low_lit_in;
      result.shown_value     = value_in;
      result.load_rejected   = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= tdcd_pkg::RADIX_RESET;
         count_down_ff   <= 1'b0;
         period_ff       <= tdcd_pkg::PERIOD_RESET;
         output_en_ff    <= 1'b0;
         count_en_ff     <= 1'b0;
         value_ff        <= '0;
         high_digit_ff   <= '0;
         low_digit_ff    <= '0;
         low_active_ff   <= 1'b0;
         period_count_ff <= '0;
         segment_ff      <= '0;
         high_lit_ff     <= 1'b0;
         low_lit_ff      <= 1'b0;
      end else begin
         radix_ff        <= radix_in;
         count_down_ff   <= count_down_in;
         period_ff       <= period_in;
         output_en_ff    <= output_en_in;
         count_en_ff     <= count_en_in;
         value_ff        <= value_in;
         high_digit_ff   <= high_digit_in;
         low_digit_ff    <= low_digit_in;
         low_active_ff   <= low_active_in;
         period_count_ff <= period_count_in;
         segment_ff      <= segment_in;
         high_lit_ff     <= high_lit_in;
         low_lit_ff      <= low_lit_in;
      end
   end

endmodule

FILE: test/two_digit_radix_counter_display_top_test.sv
// Self-checking testbench for the two-digit radix counter display: directed and random beats.
`timescale 1ns / 100ps

module two_digit_radix_counter_display_top_test;
   import tdcd_pkg::*;

   // Segment codes for digits 0..15, kept apart from the design's own table
   localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [16] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
      7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
   };
   // Selector code with no base of its own, and the highest index the port can carry
   localparam logic [RADIX_W-1:0]   RADIX_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPAN_LAST = 3'd7;
   localparam int unsigned RANDOM_ITEMS  = 800;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned IDLE_PERCENT  = 31;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Display counter predictor with a queue of expected result beats
   class display_scoreboard;
      logic [RADIX_W-1:0]  radix_sel;
      logic                down_dir;
      logic [PERIOD_W-1:0] period_len;
      logic                show_en;
      logic                step_en;
      logic [VALUE_W-1:0]  value;
      logic [DIGIT_W-1:0]  high_dig;
      logic [DIGIT_W-1:0]  low_dig;
      logic                low_turn;
      logic [PERIOD_W-1:0] tick_count;
      logic [SEG_W-1:0]    seg_latch;
      logic                high_lit;
      logic                low_lit;
      result_type          expected_q[$];
      int unsigned errors, reported, n_loads, n_refused, n_ticks, n_steps, n_writes, n_checked;

      function new();
         radix_sel  = RADIX_RESET;
         down_dir   = 1'b0;
         period_len = PERIOD_RESET;
         show_en    = 1'b0;
         step_en    = 1'b0;
         value      = '0;
         high_dig   = '0;
         low_dig    = '0;
         low_turn   = 1'b0;
         tick_count = '0;
         seg_latch  = '0;
         high_lit   = 1'b0;
         low_lit    = 1'b0;
         errors = 0; reported = 0; n_loads = 0; n_refused = 0;
         n_ticks = 0; n_steps = 0; n_writes = 0; n_checked = 0;
      endfunction

      function int unsigned base_now();
         case (radix_sel)
            RADIX_BIN: return 2;
            RADIX_HEX: return 16;
            default:   return 10;
         endcase
      endfunction

      function logic [VALUE_W-1:0] top_value();
         return VALUE_W'(base_now() * base_now() - 1);
      endfunction

      function void resplit();
         int unsigned b;
         b = base_now();
         high_dig = DIGIT_W'(value / b);
         low_dig  = DIGIT_W'(value % b);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void flag(string what, logic [RSP_DATA_W-1:0] want, logic [RSP_DATA_W-1:0] got);
         errors++;
         if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
         end
      endfunction

      // Apply a register write beat
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         n_writes++;
         case (idx)
            REG_RADIX_SELECT: radix_sel = data[RADIX_W-1:0];
            REG_COUNT_DOWN:   down_dir = data[0];
            REG_COUNT_PERIOD: period_len = data;
            REG_OUTPUT_ENABLE: begin
               show_en = data[0];
               if (!show_en) begin
                  high_lit = 1'b0;
                  low_lit  = 1'b0;
               end
            end
            REG_COUNT_ENABLE: begin
               step_en = data[0];
               if (!step_en) tick_count = '0;
            end
            default: ;
         endcase
      endfunction

      // Advance the state for one accepted input beat and queue its result
      function void note_item(logic mode, logic [VALUE_W-1:0] load);
         logic [VALUE_W-1:0] mx;
         logic               refused;
         result_type         want;
         mx = top_value();
         refused = 1'b0;
         if (mode == MODE_LOAD) begin
            n_loads++;
            if (load <= mx) begin
               value = load;
               resplit();
            end else begin
               refused = 1'b1;
               n_refused++;
            end
         end else begin
            n_ticks++;
            // flip the active display using the digits from before this beat
            if (show_en) begin
               low_turn = ~low_turn;
               if (low_turn) begin
                  high_lit  = 1'b0;
                  seg_latch = DIGIT_SEGMENTS[low_dig];
                  low_lit   = 1'b1;
               end else begin
                  low_lit = 1'b0;
                  if (high_dig == 0) begin
                     high_lit = 1'b0;
                  end else begin
                     seg_latch = DIGIT_SEGMENTS[high_dig];
                     high_lit  = 1'b1;
                  end
               end
            end
            // step the value once per period, wrapping at either end
            if (step_en) begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= period_len) begin
                  tick_count = '0;
                  n_steps++;
                  if (!down_dir) value = (value >= mx) ? '0 : value + 1'b1;
                  else value = (value == 0) ? mx : value - 1'b1;
                  if (value <= mx) resplit();
               end
            end else begin
               tick_count = '0;
            end
         end
         want.segments        = seg_latch;
         want.high_display_on = high_lit;
         want.low_display_on  = low_lit;
         want.shown_value     = value;
         want.load_rejected   = refused;
         expected_q.push_back(want);
      endfunction

      // Compare a result beat with the oldest expectation
      function void check_result(logic [RSP_DATA_W-1:0] word);
         result_type want;
         n_checked++;
         if (expected_q.size() == 0) begin
            flag("result beat with none expected", '0, word);
            return;
         end
         want = expected_q.pop_front();
         if (word[6:0] !== want.segments)
            flag("segments", RSP_DATA_W'(want.segments), RSP_DATA_W'(word[6:0]));
         if (word[7] !== want.high_display_on)
            flag("high_display_on", RSP_DATA_W'(want.high_display_on), RSP_DATA_W'(word[7]));
         if (word[8] !== want.low_display_on)
            flag("low_display_on", RSP_DATA_W'(want.low_display_on), RSP_DATA_W'(word[8]));
         if (word[16:9] !== want.shown_value)
            flag("shown_value", RSP_DATA_W'(want.shown_value), RSP_DATA_W'(word[16:9]));
         if (word[17] !== want.load_rejected)
            flag("load_rejected", RSP_DATA_W'(want.load_rejected), RSP_DATA_W'(word[17]));
         if (word[23:18] !== 6'd0)
            flag("padding bits", '0, RSP_DATA_W'(word[23:18]));
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   bit                    steady     = 1'b0;
   display_scoreboard     sb         = new();

   two_digit_radix_counter_display_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side at random, except in the steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      if (!reset && req_tvalid && req_tready) sb.note_item(req_tuser[0], req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Hold valid until the beat is taken; leave it high for a following beat
   task automatic send_item(logic mode, logic [VALUE_W-1:0] load);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= mode;
      req_tdata    <= load;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(MODE_TICK, VALUE_W'($urandom));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and hold off until every expected result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Sometimes set unused upper data bits, which the register must ignore
   function automatic logic [CSR_DATA_W-1:0] pad_noise(logic [CSR_DATA_W-1:0] field,
                                                       int unsigned width);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'($urandom) << width;
      return ($urandom_range(0, 3) == 0) ? (field | noise) : field;
   endfunction

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                        (csr_valid && csr_ready)))
            quiet = 0;
         else
            quiet++;
      end
      $display("two_digit_radix_counter_display_top_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned         random_sent;
      int unsigned         burst;
      int unsigned         pick;
      int unsigned         phases;
      logic [PERIOD_W-1:0] period;
      logic [VALUE_W-1:0]  load;
      random_sent = 0;
      phases = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: decimal, display and counting off; loads at and past the limit
      send_item(MODE_LOAD, 8'd0);
      send_item(MODE_LOAD, 8'd99);
      send_item(MODE_LOAD, 8'd100);
      send_item(MODE_LOAD, 8'd255);
      send_tick();
      drain_results();

      // Multiplex: a zero high digit stays dark, then a two-digit value
      write_reg(REG_OUTPUT_ENABLE, 16'd1);
      send_item(MODE_LOAD, 8'd7);
      send_tick();
      send_tick();
      send_item(MODE_LOAD, 8'd42);
      send_tick();
      send_tick();
      drain_results();

      // Hex count up from the top wraps to zero
      write_reg(REG_RADIX_SELECT, CSR_DATA_W'(RADIX_HEX));
      write_reg(REG_COUNT_PERIOD, 16'd1);
      write_reg(REG_COUNT_ENABLE, 16'd1);
      send_item(MODE_LOAD, 8'hFF);
      send_tick();
      drain_results();

      // Binary, count down, period zero steps on every tick
      write_reg(REG_RADIX_SELECT, CSR_DATA_W'(RADIX_BIN));
      write_reg(REG_COUNT_DOWN, 16'd1);
      write_reg(REG_COUNT_PERIOD, 16'd0);
      send_item(MODE_LOAD, 8'd0);
      send_tick();
      send_tick();
      drain_results();

      // Radix change leaves a value above the new limit; digits hold, then up wraps
      write_reg(REG_RADIX_SELECT, CSR_DATA_W'(RADIX_HEX));
      send_item(MODE_LOAD, 8'd200);
      drain_results();
      write_reg(REG_RADIX_SELECT, CSR_DATA_W'(RADIX_BIN));
      send_tick();
      drain_results();
      write_reg(REG_COUNT_DOWN, 16'd0);
      send_tick();
      drain_results();

      // Unused selector acts as decimal; lower the period below the running count
      write_reg(REG_RADIX_SELECT, CSR_DATA_W'(RADIX_SPARE));
      write_reg(REG_COUNT_PERIOD, 16'd5);
      send_item(MODE_LOAD, 8'd99);
      send_tick();
      send_tick();
      send_tick();
      drain_results();
      write_reg(REG_COUNT_PERIOD, 16'd2);
      send_tick();
      drain_results();

      // Disabling darkens and clears; out-of-range index is ignored
      write_reg(REG_COUNT_ENABLE, 16'd0);
      write_reg(REG_OUTPUT_ENABLE, 16'd0);
      write_reg(REG_COUNT_PERIOD, 16'hFFFF);
      write_reg(REG_SPAN_LAST, 16'hFFFF);
      send_tick();

      // Random phases: new settings while idle, then a burst of beats
      while (random_sent < RANDOM_ITEMS) begin
         drain_results();
         if (phases == 0 || $urandom_range(0, 1) == 1)
            write_reg(REG_RADIX_SELECT, pad_noise(CSR_DATA_W'($urandom_range(0, 3)), RADIX_W));
         if (phases == 0 || $urandom_range(0, 1) == 1)
            write_reg(REG_COUNT_DOWN, pad_noise(CSR_DATA_W'($urandom_range(0, 1)), 1));
         if (phases == 0 || $urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) period = PERIOD_W'($urandom_range(0, 6));
            else if (pick < 85) period = PERIOD_W'($urandom_range(7, 40));
            else if (pick < 95) period = PERIOD_W'($urandom);
            else period = 16'hFFFF;
            write_reg(REG_COUNT_PERIOD, period);
         end
         if (phases == 0 || $urandom_range(0, 1) == 1)
            write_reg(REG_OUTPUT_ENABLE, pad_noise(CSR_DATA_W'($urandom_range(0, 99) < 85), 1));
         if (phases == 0 || $urandom_range(0, 1) == 1)
            write_reg(REG_COUNT_ENABLE, pad_noise(CSR_DATA_W'($urandom_range(0, 99) < 80), 1));
         if ($urandom_range(0, 19) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_COUNT_ENABLE + 1, REG_SPAN_LAST)),
                      CSR_DATA_W'($urandom));
         phases++;
         burst = $urandom_range(10, 50);
         repeat (burst) begin
            steady = (random_sent >= 250 && random_sent < 400);
            if ($urandom_range(0, 99) < 70) begin
               send_tick();
            end else begin
               if ($urandom_range(0, 3) != 0) load = VALUE_W'($urandom_range(0, sb.top_value()));
               else load = VALUE_W'($urandom_range(0, 255));
               send_item(MODE_LOAD, load);
            end
            random_sent++;
         end
      end
      steady = 1'b0;

      // Wait out the last results, then check that no expected result is left undelivered
      drain_results();
      repeat (10) @(negedge clock);
      if (sb.pending() != 0)
         sb.flag("results never delivered", RSP_DATA_W'(sb.pending()), '0);

      $display("run covered %0d loads (%0d refused), %0d ticks, %0d count steps over %0d phases",
               sb.n_loads, sb.n_refused, sb.n_ticks, sb.n_steps, phases);
      $display("%0d register writes, %0d result beats checked, %0d mismatches",
               sb.n_writes, sb.n_checked, sb.errors);
      if (sb.errors == 0)
         $display("two_digit_radix_counter_display_top_test: done, clean");
      else
         $display("two_digit_radix_counter_display_top_test: done, errors");
      $finish;
   end

endmodule
